FILE: hdl/sida_pkg.sv
// shared constants and helpers for the signed integer to decimal text converter
package sida_pkg;

	localparam int VALUE_BITS_DEF = 32;

	// magnitude bits folded into the bcd register per conversion step
	localparam int STEP_BITS = 4;

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [3:0] DIGIT_MAX  = 4'd9;

	// decimal digits of 2^(bits-1), log10(2) approximated as 0.30103
	function automatic int ndig_of(input int bits);
		return ((bits - 1) * 30103) / 100000 + 1;
	endfunction

	// magnitude width padded to a whole number of steps
	function automatic int pad_of(input int bits);
		return ((bits + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	endfunction

	// shift-and-add-3 correction of one bcd digit
	function automatic logic [3:0] dabble_digit(input logic [3:0] d);
		return (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

endpackage

FILE: hdl/sida_front.sv
// input side: sign split, magnitude and a two-entry queue toward the converter
module sida_front #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF,
	parameter int PAD_W      = sida_pkg::pad_of(sida_pkg::VALUE_BITS_DEF)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         q_valid,
	input  logic                         q_ready,
	output logic                         q_neg,
	output logic [PAD_W-1:0]             q_mag
);
	import sida_pkg::*;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] abs_val;
	logic                  neg_mem [2];
	logic [PAD_W-1:0]      mag_mem [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  push;
	logic                  pop;

	// the most negative value wraps to 2^(bits-1), which is its true magnitude
	assign raw     = value;
	assign abs_val = raw[VALUE_BITS-1] ? ('0 - raw) : raw;

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_neg    = neg_mem[rd_ptr_q];
	assign q_mag    = mag_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			neg_mem[wr_ptr_q] <= raw[VALUE_BITS-1];
			mag_mem[wr_ptr_q] <= PAD_W'(abs_val);
		end
	end

endmodule

FILE: hdl/sida_conv.sv
// binary to bcd converter, shift-and-add-3 over several bits per cycle
module sida_conv #(
	parameter int PAD_W = sida_pkg::pad_of(sida_pkg::VALUE_BITS_DEF),
	parameter int NDIG  = sida_pkg::ndig_of(sida_pkg::VALUE_BITS_DEF)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  logic                q_neg,
	input  logic [PAD_W-1:0]    q_mag,
	output logic                res_valid,
	input  logic                res_ready,
	output logic                res_neg,
	output logic [NDIG*4-1:0]   res_bcd
);
	import sida_pkg::*;

	localparam int BCD_W = NDIG * 4;
	localparam int STEPS = PAD_W / STEP_BITS;
	localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic              active_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [PAD_W-1:0]  mag_q;
	logic [BCD_W-1:0]  bcd_q;
	logic              neg_q;
	logic [PAD_W-1:0]  mag_nxt;
	logic [BCD_W-1:0]  bcd_nxt;
	logic              start;

	assign q_ready   = !active_q && !done_q;
	assign start     = q_valid && q_ready;
	assign res_valid = done_q;
	assign res_neg   = neg_q;
	assign res_bcd   = bcd_q;

	always_comb begin
		mag_nxt = mag_q;
		bcd_nxt = bcd_q;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int k = 0; k < NDIG; k++) begin
				bcd_nxt[k*4 +: 4] = dabble_digit(bcd_nxt[k*4 +: 4]);
			end
			bcd_nxt = {bcd_nxt[BCD_W-2:0], mag_nxt[PAD_W-1]};
			mag_nxt = {mag_nxt[PAD_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= CW'(STEPS - 1);
			end else if (active_q) begin
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end else if (done_q && res_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= q_mag;
			bcd_q <= '0;
			neg_q <= q_neg;
		end else if (active_q) begin
			mag_q <= mag_nxt;
			bcd_q <= bcd_nxt;
		end
	end

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(active_q && done_q))
		else $error("converter busy and holding a result at once");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q <= CW'(STEPS - 1)))
		else $error("step counter out of range");

endmodule

FILE: hdl/sida_emit.sv
// character sequencer: sign, then digits without leading zeros, into an output register
module sida_emit #(
	parameter int NDIG = sida_pkg::ndig_of(sida_pkg::VALUE_BITS_DEF)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	output logic              res_ready,
	input  logic              res_neg,
	input  logic [NDIG*4-1:0] res_bcd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        char_code,
	output logic              last
);
	import sida_pkg::*;

	localparam int IW = $clog2(NDIG);

	logic              busy_q;
	logic              neg_pend_q;
	logic              started_q;
	logic [IW-1:0]     idx_q;
	logic [NDIG*4-1:0] digits_q;
	logic              ov_q;
	logic [7:0]        char_q;
	logic              last_q;
	logic [3:0]        digit;
	logic              slot_free;
	logic              load;
	logic              emit_minus;
	logic              skip;
	logic              emit_digit;
	logic              idx_zero;

	assign digit      = digits_q[idx_q*4 +: 4];
	assign idx_zero   = (idx_q == '0);
	assign slot_free  = !ov_q || out_ready;
	assign res_ready  = !busy_q;
	assign load       = res_valid && !busy_q;
	assign emit_minus = busy_q && neg_pend_q && slot_free;
	// leading zero positions are dropped, the units digit always goes out
	assign skip       = busy_q && !neg_pend_q && !started_q && (digit == 4'd0) && !idx_zero;
	assign emit_digit = busy_q && !neg_pend_q && !skip && slot_free;

	assign out_valid = ov_q;
	assign char_code = char_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			neg_pend_q <= 1'b0;
			started_q  <= 1'b0;
			idx_q      <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (emit_minus || emit_digit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;

			if (load) begin
				busy_q     <= 1'b1;
				neg_pend_q <= res_neg;
				started_q  <= 1'b0;
				idx_q      <= IW'(NDIG - 1);
			end else if (emit_minus) begin
				neg_pend_q <= 1'b0;
			end else if (skip) begin
				idx_q <= idx_q - IW'(1);
			end else if (emit_digit) begin
				started_q <= 1'b1;
				if (idx_zero) busy_q <= 1'b0;
				else idx_q <= idx_q - IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) digits_q <= res_bcd;
		if (emit_minus) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (emit_digit) begin
			char_q <= CHAR_ZERO + {4'd0, digit};
			last_q <= idx_zero;
		end
	end

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && last_q) |-> (char_q >= CHAR_ZERO && char_q <= CHAR_ZERO + {4'd0, DIGIT_MAX}))
		else $error("final character is not a digit");

	a_minus_then_more: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && char_q == CHAR_MINUS) |-> (busy_q && !last_q))
		else $error("minus sign without digits behind it");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !(emit_digit && idx_zero)) |=> busy_q)
		else $error("sequencer dropped a number before its final digit");

endmodule

FILE: hdl/signed_int_to_decimal_ascii_top.sv
// top level of the signed integer to decimal text converter
// a number is registered into the queue, then runs STEPS = ceil(VALUE_BITS/4) converter steps,
//   is handed to the sequencer and loaded there; a minus sign, if any, goes into the output register,
//   then leading zero positions are skipped before the first digit goes out; out_ready can stall it
// the converter takes the next number once the sequencer has loaded the current one; the sequencer
//   loads a new number only after the last digit, with a load and a visit to every digit position once
// reset: arst_n clears queue pointers, converter and sequencer control; nothing else to clear
module signed_int_to_decimal_ascii_top #(
	parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   char_code,
	output logic                         last
);
	import sida_pkg::*;

	// padded magnitude width and decimal digits of the largest magnitude
	localparam int PAD_W = pad_of(VALUE_BITS);
	localparam int NDIG  = ndig_of(VALUE_BITS);

	// queue to converter transfer
	logic             q_valid;
	logic             q_ready;
	logic             q_neg;
	logic [PAD_W-1:0] q_mag;

	// converter to sequencer transfer
	logic              res_valid;
	logic              res_ready;
	logic              res_neg;
	logic [NDIG*4-1:0] res_bcd;

	// front: sign split and magnitude, two numbers of slack
	sida_front #(
		.VALUE_BITS(VALUE_BITS),
		.PAD_W     (PAD_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value   (value),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_neg   (q_neg),
		.q_mag   (q_mag)
	);

	// back, first half: magnitude to bcd, four bits per cycle
	sida_conv #(
		.PAD_W(PAD_W),
		.NDIG (NDIG)
	) u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_neg    (q_neg),
		.q_mag    (q_mag),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_neg  (res_neg),
		.res_bcd  (res_bcd)
	);

	// back, second half: one character per transfer, converter runs ahead on the next number
	sida_emit #(
		.NDIG(NDIG)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_neg  (res_neg),
		.res_bcd  (res_bcd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code),
		.last     (last)
	);

endmodule
